// ----- src/life_automaton_generation_assert.svh -----
// Assertion macros used by the checker file of the life generation block
`ifndef LIFE_AUTOMATON_GENERATION_ASSERT_SVH
`define LIFE_AUTOMATON_GENERATION_ASSERT_SVH

// Check cons in the same cycle as ante
`define LAG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check cons from the cycle after ante
`define LAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/lag_pkg.sv -----
// Shared constants and operation codes of the life generation block
package lag_pkg;

  localparam int unsigned GRID_ROWS_DEF = 32;
  localparam int unsigned GRID_COLS_DEF = 64;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

endpackage

// ----- src/lag_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module lag_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/life_automaton_generation.sv -----
// Life generation engine: bounded B3/S23 grid in two RAM banks, one cell per cycle
//
// Input channel (in_valid_i/in_ready_o) carries op_i, row_i, col_i, alive_i.
// Output channel (out_valid_o/out_ready_i) returns one cell_alive_o per item.
// op write stores alive_i into the current grid and echoes it; op read returns
// the cell; op step computes the next generation into the other bank and
// swaps banks, returning 0. Unused op codes and cells outside the grid give 0.
// The block takes one item at a time; in_ready_o is high only while idle.
// A write goes from idle through ST_DONE into the output register; a read first
// passes ST_READ, where the registered RAM data arrives. A step runs a scan that
// reads one cell per cycle from the active bank's read port through a two-row
// line buffer and writes one new cell per cycle into the other bank.
// After reset a clearing pass writes bank 0 to dead, one cell a cycle;
// in_ready_o stays low during it.
// The result sits in an output register: a stalled receiver holds it there,
// and the block still accepts and works on the next item, waiting only to
// hand over its own result until the register is free.
module life_automaton_generation #(
  parameter int unsigned GRID_ROWS = lag_pkg::GRID_ROWS_DEF,
  parameter int unsigned GRID_COLS = lag_pkg::GRID_COLS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [4:0] row_i,
  input  logic [5:0] col_i,
  input  logic       alive_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       cell_alive_o
);

  localparam int unsigned CELL_COUNT = GRID_ROWS * GRID_COLS;
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);
  localparam int unsigned LAST_STEP  = CELL_COUNT + GRID_COLS + 2;
  localparam int unsigned STEP_W     = $clog2(LAST_STEP + 1);
  localparam int unsigned FIRST_WR   = GRID_COLS + 3;
  localparam int unsigned ROW_W      = $clog2(GRID_ROWS);
  localparam int unsigned COL_W      = $clog2(GRID_COLS);
  localparam int unsigned SR_LEN     = 2 * GRID_COLS + 3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_GEN,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [ADDR_W-1:0]  cen_idx_q, cen_idx_d;
  logic [ROW_W-1:0]   cen_row_q, cen_row_d;
  logic [COL_W-1:0]   cen_col_q, cen_col_d;
  logic               bank_q, bank_d;
  logic               rd_vld_q, rd_vld_d;
  logic               out_valid_q, out_valid_d;
  logic               cell_alive_q, cell_alive_d;
  logic               res_q, res_d;
  logic               inside_q, inside_d;
  logic [SR_LEN-1:0]  sr_q, sr_d;

  logic               in_xfer;
  logic               in_grid;
  logic [ADDR_W-1:0]  op_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_data;
  logic               we0, we1;
  logic               rdata0, rdata1, rd_bit;
  logic               gen_wr;
  logic [7:0]         nbr;
  logic [3:0]         nbr_cnt;
  logic               next_cell;
  logic               top_ok, bot_ok, lft_ok, rgt_ok;
  logic               load_out;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_grid    = (32'(row_i) < 32'(GRID_ROWS)) && (32'(col_i) < 32'(GRID_COLS));
  assign op_addr    = ADDR_W'(row_i) * ADDR_W'(GRID_COLS) + ADDR_W'(col_i);
  assign rd_bit     = bank_q ? rdata1 : rdata0;
  assign gen_wr     = (state_q == ST_GEN) && (step_q >= STEP_W'(FIRST_WR));

  // Window around the center cell, taken from fixed taps of the line buffer
  assign top_ok = (cen_row_q != ROW_W'(0));
  assign bot_ok = (cen_row_q != ROW_W'(GRID_ROWS - 1));
  assign lft_ok = (cen_col_q != COL_W'(0));
  assign rgt_ok = (cen_col_q != COL_W'(GRID_COLS - 1));

  assign nbr[0] = sr_q[0] && bot_ok && rgt_ok;
  assign nbr[1] = sr_q[1] && bot_ok;
  assign nbr[2] = sr_q[2] && bot_ok && lft_ok;
  assign nbr[3] = sr_q[GRID_COLS] && rgt_ok;
  assign nbr[4] = sr_q[GRID_COLS+2] && lft_ok;
  assign nbr[5] = sr_q[2*GRID_COLS] && top_ok && rgt_ok;
  assign nbr[6] = sr_q[2*GRID_COLS+1] && top_ok;
  assign nbr[7] = sr_q[2*GRID_COLS+2] && top_ok && lft_ok;

  always_comb begin
    nbr_cnt = 4'd0;
    for (int i = 0; i < 8; i++) begin
      nbr_cnt = nbr_cnt + 4'(nbr[i]);
    end
  end

  assign next_cell = (nbr_cnt == 4'd3) || ((nbr_cnt == 4'd2) && sr_q[GRID_COLS+1]);

  // Shared write and read ports of the two banks
  always_comb begin
    wr_addr = op_addr;
    wr_data = alive_i;
    we0     = 1'b0;
    we1     = 1'b0;
    rd_addr = op_addr;
    unique case (state_q)
      ST_CLEAR: begin
        wr_addr = step_q[ADDR_W-1:0];
        wr_data = 1'b0;
        we0     = 1'b1;
      end
      ST_IDLE: begin
        if (in_xfer && in_grid && (op_i == lag_pkg::OP_WRITE)) begin
          we0 = !bank_q;
          we1 = bank_q;
        end
      end
      ST_GEN: begin
        wr_addr = cen_idx_q;
        wr_data = next_cell;
        we0     = gen_wr && bank_q;
        we1     = gen_wr && !bank_q;
        rd_addr = (step_q < STEP_W'(CELL_COUNT)) ? step_q[ADDR_W-1:0] : '0;
      end
      default: begin
      end
    endcase
  end

  lag_ram #(
    .WIDTH(1),
    .DEPTH(CELL_COUNT)
  ) u_bank0 (
    .clk_i  (clk_i),
    .we_i   (we0),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(rdata0)
  );

  lag_ram #(
    .WIDTH(1),
    .DEPTH(CELL_COUNT)
  ) u_bank1 (
    .clk_i  (clk_i),
    .we_i   (we1),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(rdata1)
  );

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    cen_idx_d    = cen_idx_q;
    cen_row_d    = cen_row_q;
    cen_col_d    = cen_col_q;
    bank_d       = bank_q;
    res_d        = res_q;
    inside_d     = inside_q;
    rd_vld_d     = (state_q == ST_GEN) && (step_q < STEP_W'(CELL_COUNT));
    sr_d         = sr_q;
    cell_alive_d = cell_alive_q;
    out_valid_d  = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        if (step_q == STEP_W'(CELL_COUNT - 1)) begin
          step_d  = '0;
          state_d = ST_IDLE;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          inside_d = in_grid;
          unique case (op_i)
            lag_pkg::OP_WRITE: begin
              res_d   = in_grid && alive_i;
              state_d = ST_DONE;
            end
            lag_pkg::OP_STEP: begin
              step_d    = '0;
              cen_idx_d = '0;
              cen_row_d = '0;
              cen_col_d = '0;
              state_d   = ST_GEN;
            end
            lag_pkg::OP_READ: begin
              state_d = ST_READ;
            end
            default: begin
              res_d   = 1'b0;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_READ: begin
        res_d   = inside_q && rd_bit;
        state_d = ST_DONE;
      end
      ST_GEN: begin
        // Shift the cell read last cycle into the line buffer, zeros past the end
        sr_d = {sr_q[SR_LEN-2:0], rd_vld_q && rd_bit};
        if (gen_wr) begin
          cen_idx_d = cen_idx_q + ADDR_W'(1);
          if (cen_col_q == COL_W'(GRID_COLS - 1)) begin
            cen_col_d = '0;
            cen_row_d = cen_row_q + ROW_W'(1);
          end else begin
            cen_col_d = cen_col_q + COL_W'(1);
          end
        end
        if (step_q == STEP_W'(LAST_STEP)) begin
          step_d  = '0;
          bank_d  = !bank_q;
          res_d   = 1'b0;
          state_d = ST_DONE;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_d  = 1'b1;
          cell_alive_d = res_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      step_q       <= '0;
      cen_idx_q    <= '0;
      cen_row_q    <= '0;
      cen_col_q    <= '0;
      bank_q       <= 1'b0;
      rd_vld_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      cell_alive_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      cen_idx_q    <= cen_idx_d;
      cen_row_q    <= cen_row_d;
      cen_col_q    <= cen_col_d;
      bank_q       <= bank_d;
      rd_vld_q     <= rd_vld_d;
      out_valid_q  <= out_valid_d;
      cell_alive_q <= cell_alive_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    inside_q <= inside_d;
    sr_q     <= sr_d;
  end

  assign out_valid_o  = out_valid_q;
  assign cell_alive_o = cell_alive_q;

endmodule

// ----- src/lag_checker.sv -----
// Port-level checks for the life generation block, bound to its top level
`include "life_automaton_generation_assert.svh"

module lag_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] op_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       cell_alive_o
);

  // Clearing pass right after reset keeps the input side closed
  `LAG_ASSERT_NOW(a_clear_after_reset, clk_i, rst_ni, !$past(rst_ni), !in_ready_o)
  // One item at a time: no transfer in the cycle after a transfer
  `LAG_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // A generation scan keeps the block busy after the transfer
  `LAG_ASSERT_NEXT(a_step_busy, clk_i, rst_ni, in_valid_i && in_ready_o && op_i == lag_pkg::OP_STEP, !in_ready_o ##1 !in_ready_o)
  // A stalled result holds
  `LAG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(cell_alive_o))

endmodule

bind life_automaton_generation lag_checker u_lag_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .op_i        (op_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .cell_alive_o(cell_alive_o)
);
